@@ rtl/core/lrc_pkg.sv @@
// shared types and constants of the lru row cache tag store
package lrc_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int ROW_W     = 16;
    localparam int AGE_W     = 32;
    localparam int SLOT_W    = 8;
    localparam int KIND_W    = 2;

    localparam logic [ROW_W-1:0] EMPTY_ROW = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

endpackage

@@ rtl/core/lrc_if.sv @@
// request and response channels of the lru row cache tag store
interface lrc_in_if import lrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row_number;

    modport source (output valid, output kind, output row_number, input ready);
    modport sink   (input valid, input kind, input row_number, output ready);
endinterface

interface lrc_out_if import lrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  evicted_row;

    modport source (output valid, output hit, output slot, output evicted_row, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_row, output ready);
endinterface

@@ rtl/core/lrc_ram.sv @@
// generic simple dual port ram with registered read
module lrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lru_row_cache_tags_unit.sv @@
// lru row cache tag store: fully associative, least recently used replacement
//
// i_in carries one command per beat: kind (lookup, delete, clear) and a row number.
// o_out returns exactly one beat per command: hit flag, slot and evicted row.
// Row numbers and age stamps live in two memories of SLOTS entries each.
// A lookup reads every slot once, tracking the first match and the oldest slot,
// then writes the age (and the row on a miss) before its response is registered.
// A delete rewrites every slot in a read-modify-write pass. A clear writes every
// slot, and the unused kind value answers without any pass over the memories.
// One command is in flight at a time; i_in.ready is high while the block idles,
// also when a response still waits in the output register.
// After reset the block runs a clearing pass over both memories with i_in.ready
// low. A stall on o_out holds the response in its register; a finished command
// then waits until the register frees before it idles.
module lru_row_cache_tags_unit import lrc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrc_in_if.sink     i_in,
    lrc_out_if.source  o_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [ROW_W-1:0]  r_row;
    logic [IW-1:0]     r_addr;
    logic              r_issue;
    logic              r_dv;
    logic              r_dlast;
    logic [IW-1:0]     r_daddr;
    logic              r_found;
    logic [IW-1:0]     r_hit_slot;
    logic [AGE_W-1:0]  r_min_age;
    logic [IW-1:0]     r_lru;
    logic [ROW_W-1:0]  r_lru_row;
    logic [AGE_W-1:0]  r_counter;
    logic              r_clr_cmd;
    logic              r_res_hit;
    logic [SLOT_W-1:0] r_res_slot;
    logic [ROW_W-1:0]  r_res_evict;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;
    logic [ROW_W-1:0]  r_out_evict;

    logic              row_we;
    logic [IW-1:0]     row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_q;
    logic              age_we;
    logic [IW-1:0]     age_waddr;
    logic [AGE_W-1:0]  age_wdata;
    logic [AGE_W-1:0]  age_q;

    logic              match;
    logic              older;
    logic [ROW_W-1:0]  del_row;
    logic [IW-1:0]     tgt_slot;

    lrc_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS), .AW(IW)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_addr),
        .o_rdata (row_q)
    );

    lrc_ram #(.WIDTH(AGE_W), .DEPTH(SLOTS), .AW(IW)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (r_addr),
        .o_rdata (age_q)
    );

    // per-slot compare on the data returned from the memories
    assign match    = (row_q == r_row);
    assign older    = (r_daddr == '0) || (age_q < r_min_age);
    assign tgt_slot = r_found ? r_hit_slot : r_lru;

    always_comb begin
        if (match) begin
            del_row = EMPTY_ROW;
        end else if (row_q > r_row && row_q != EMPTY_ROW) begin
            del_row = row_q - 1'b1;
        end else begin
            del_row = row_q;
        end
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_daddr;
        row_wdata = del_row;
        age_we    = 1'b0;
        age_waddr = tgt_slot;
        age_wdata = r_counter + 1'b1;
        case (r_state)
            S_INIT: begin
                row_we    = 1'b1;
                row_waddr = r_addr;
                row_wdata = EMPTY_ROW;
                age_we    = 1'b1;
                age_waddr = r_addr;
                age_wdata = '0;
            end
            S_SCAN: begin
                row_we = r_dv && (r_kind == KIND_DELETE);
            end
            S_UPD: begin
                age_we    = 1'b1;
                row_we    = !r_found;
                row_waddr = r_lru;
                row_wdata = r_row;
            end
            default: begin
                row_we = 1'b0;
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_out_hit;
    assign o_out.slot        = r_out_slot;
    assign o_out.evicted_row = r_out_evict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_addr    <= '0;
            r_clr_cmd <= 1'b0;
            r_counter <= '0;
            r_out_vld <= 1'b0;
            r_issue   <= 1'b0;
            r_dv      <= 1'b0;
            r_kind    <= KIND_LOOKUP;
        end else begin
            if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_addr    <= '0;
                        r_counter <= '0;
                        r_state   <= r_clr_cmd ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind      <= t_kind'(i_in.kind);
                        r_row       <= i_in.row_number;
                        r_addr      <= '0;
                        r_found     <= 1'b0;
                        r_issue     <= 1'b1;
                        r_dv        <= 1'b0;
                        r_res_hit   <= 1'b0;
                        r_res_slot  <= '0;
                        r_res_evict <= EMPTY_ROW;
                        case (t_kind'(i_in.kind))
                            KIND_LOOKUP: r_state <= S_SCAN;
                            KIND_DELETE: r_state <= S_SCAN;
                            KIND_CLEAR: begin
                                r_clr_cmd <= 1'b1;
                                r_state   <= S_INIT;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, data checked in the cycle after
                    r_dv <= r_issue;
                    if (r_issue) begin
                        r_daddr <= r_addr;
                        r_dlast <= (r_addr == LAST);
                        r_addr  <= r_addr + 1'b1;
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_dv) begin
                        if (match && !r_found) begin
                            r_found    <= 1'b1;
                            r_hit_slot <= r_daddr;
                        end
                        if (older) begin
                            r_min_age <= age_q;
                            r_lru     <= r_daddr;
                            r_lru_row <= row_q;
                        end
                        if (r_dlast) begin
                            r_dv    <= 1'b0;
                            r_addr  <= '0;
                            r_state <= (r_kind == KIND_LOOKUP) ? S_UPD : S_DONE;
                        end
                    end
                end
                S_UPD: begin
                    r_counter   <= r_counter + 1'b1;
                    r_res_hit   <= r_found;
                    r_res_slot  <= SLOT_W'(tgt_slot);
                    r_res_evict <= r_found ? EMPTY_ROW : r_lru_row;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_vld   <= 1'b1;
                        r_out_hit   <= r_res_hit;
                        r_out_slot  <= r_res_slot;
                        r_out_evict <= r_res_evict;
                        r_clr_cmd   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ bench/lrc_tag_checker.sv @@
// tag store predictor and result comparison for the lru row cache testbench
module lrc_tag_checker import lrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lrc_in_if    i_in,
    lrc_out_if   i_out,
    output int   o_failures,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  evicted_row;
    } t_answer;

    logic [ROW_W-1:0] tag_row [SLOTS_DEF];
    logic [AGE_W-1:0] tag_age [SLOTS_DEF];
    logic [AGE_W-1:0] use_count;
    t_answer          answers_due [$];
    int               failures = 0;

    function automatic void empty_tags();
        for (int i = 0; i < SLOTS_DEF; i++) begin
            tag_row[i] = EMPTY_ROW;
            tag_age[i] = '0;
        end
        use_count = '0;
    endfunction

    function automatic t_answer predict_tag_answer(t_kind k, logic [ROW_W-1:0] r);
        t_answer a;
        int      found;
        int      pick;
        a.hit         = 1'b0;
        a.slot        = '0;
        a.evicted_row = EMPTY_ROW;
        case (k)
            KIND_LOOKUP: begin
                found = -1;
                for (int i = 0; i < SLOTS_DEF; i++)
                    if (found < 0 && tag_row[i] == r) found = i;
                if (found >= 0) begin
                    a.hit = 1'b1;
                    pick  = found;
                end else begin
                    // first slot with the smallest age wins ties
                    pick = 0;
                    for (int i = 1; i < SLOTS_DEF; i++)
                        if (tag_age[i] < tag_age[pick]) pick = i;
                    a.evicted_row = tag_row[pick];
                    tag_row[pick] = r;
                end
                a.slot        = pick[SLOT_W-1:0];
                use_count     = use_count + 1'b1;
                tag_age[pick] = use_count;
            end
            KIND_DELETE: begin
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (tag_row[i] == r)
                        tag_row[i] = EMPTY_ROW;
                    else if (tag_row[i] > r && tag_row[i] != EMPTY_ROW)
                        tag_row[i] = tag_row[i] - 1'b1;
                end
            end
            KIND_CLEAR: empty_tags();
            default: ;
        endcase
        return a;
    endfunction

    function automatic void note_failure(string what, t_answer want, t_answer got);
        if (failures < 10)
            $display("%0t: %s: expected hit=%0d slot=%0d evicted=%h, got hit=%0d slot=%0d evicted=%h",
                     $realtime, what, want.hit, want.slot, want.evicted_row,
                     got.hit, got.slot, got.evicted_row);
        failures++;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            empty_tags();
            answers_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.hit, i_out.slot, i_out.evicted_row};
                if (answers_due.size() == 0) begin
                    want = '0;
                    note_failure("result with nothing pending", want, got);
                end else begin
                    want = answers_due.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.evicted_row !== want.evicted_row)
                        note_failure("mismatch", want, got);
                end
            end
            if (i_in.valid && i_in.ready)
                answers_due.push_back(predict_tag_answer(t_kind'(i_in.kind), i_in.row_number));
            o_outstanding <= answers_due.size();
        end
        o_failures <= failures;
    end

endmodule

@@ bench/lru_row_cache_tags_unit_tb.sv @@
// testbench top for the lru row cache tag store: stimulus, flow control and verdict
module lru_row_cache_tags_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrc_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 1500;
    localparam int FILL_ITEMS   = 280;
    localparam int MIX_ITEMS    = 120;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    int   failures;
    int   outstanding;
    int   results_seen = 0;
    int   sent_items = 0;
    int   idle_cycles = 0;
    bit   calm = 1'b0;

    lrc_in_if  in_ch ();
    lrc_out_if out_ch ();

    lru_row_cache_tags_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lrc_tag_checker u_tag_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return ROW_W'($urandom_range(0, 900));
        if (r < 92) return ROW_W'($urandom_range(0, 65535));
        if (r < 96) return EMPTY_ROW;
        return 16'hFFFE;
    endfunction

    task automatic push_cmd(t_kind k, logic [ROW_W-1:0] r);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.kind       = k;
        in_ch.row_number = r;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_items++;
        // every third stretch of 50 beats runs without gaps on either side
        calm = ((sent_items / 50) % 3) == 2;
    endtask

    // stimulus and verdict
    initial begin
        int r;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_LOOKUP;
        in_ch.row_number = '0;
        i_rst_n          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        push_cmd(KIND_LOOKUP, 16'd0);
        push_cmd(KIND_LOOKUP, 16'hFFFE);
        push_cmd(KIND_LOOKUP, 16'd0);
        push_cmd(KIND_LOOKUP, EMPTY_ROW);     // hits the first empty slot
        push_cmd(KIND_LOOKUP, 16'hFFFE);
        push_cmd(KIND_LOOKUP, 16'd100);
        push_cmd(KIND_LOOKUP, 16'd200);
        push_cmd(KIND_LOOKUP, 16'd150);
        push_cmd(KIND_DELETE, 16'd100);       // renumbers everything above
        push_cmd(KIND_LOOKUP, 16'd199);
        push_cmd(KIND_DELETE, EMPTY_ROW);
        push_cmd(KIND_DELETE, 16'd5000);
        push_cmd(KIND_RSVD,   16'h5555);
        push_cmd(KIND_RSVD,   16'hAAAA);
        push_cmd(KIND_LOOKUP, 16'hAAAA);
        push_cmd(KIND_LOOKUP, 16'h5555);
        push_cmd(KIND_DELETE, 16'd0);
        push_cmd(KIND_CLEAR,  16'h1234);
        push_cmd(KIND_LOOKUP, 16'h8000);      // all ages tie after a clear
        push_cmd(KIND_LOOKUP, 16'd7);
        push_cmd(KIND_DELETE, 16'h8000);

        // mostly fresh rows so the store fills and starts evicting
        for (int n = 0; n < FILL_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_cmd(KIND_DELETE, pick_row());
            else if (r < 10)
                push_cmd(KIND_RSVD, ROW_W'($urandom_range(0, 65535)));
            else
                push_cmd(KIND_LOOKUP, ROW_W'(n * 3 + $urandom_range(0, 2)));
        end

        for (int n = 0; n < MIX_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push_cmd(KIND_LOOKUP, pick_row());
            else if (r < 88)
                push_cmd(KIND_DELETE, pick_row());
            else if (r < 93)
                push_cmd(KIND_RSVD, ROW_W'($urandom_range(0, 65535)));
            else if (r < 95)
                push_cmd(KIND_CLEAR, ROW_W'($urandom_range(0, 65535)));
            else
                push_cmd(KIND_LOOKUP, EMPTY_ROW);
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: short random stalls plus one long hold-off
    initial begin
        int stall;
        bit held;
        stall        = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held         = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else begin
                out_ch.ready = 1'b1;
                if ($urandom_range(0, 9) == 0) stall = pick_gap();
            end
        end
    end

    // beat counting and watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) results_seen++;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (i_rst_n)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
